// ----- hdl/sorted_key_binary_search_defines.svh -----
// Assertion macros for the sorted key search checker.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef SORTED_KEY_BINARY_SEARCH_DEFINES_SVH
`define SORTED_KEY_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SKSB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define SKSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sksb_pkg.sv -----
// Shared constants and types for the sorted key search block.
// No dependencies; used by the search engine, the top level and the checker.
package sksb_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int BND_W       = IDX_W + 1;
   localparam int CSR_W       = 13;
   localparam int KEY_W       = 16;
   localparam int VAL_W       = 16;
   localparam int ENTRY_W     = KEY_W + VAL_W;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_req_type;

endpackage

// ----- hdl/sorted_key_binary_search.sv -----
// Sorted key table with binary search lookup.
// Request channel (req_*): op selects a load (write one key/value entry at
// entry_index, no response) or a lookup (search_key, fallback_value).
// Response channel (rsp_*): one beat per lookup with found, result_value
// (matched value or the fallback) and match_index (0 on a miss).
// csr_wr_en/csr_wr_data set entry_count, the number of entries searched;
// counts above the table depth search the whole table. Write it only while idle.
// A load does not stall the request channel; the next beat may follow right behind it.
// A lookup makes p probes, p <= log2(depth)+1; each probe is a read of the
// table RAM followed by a compare. req_stall is high for the whole lookup.
// The response sits in an output register; while rsp_stall is high it holds,
// and a finished search waits with its RAM read data held until it drains.
// Reset clears entry_count and the response valid; the table itself is not
// cleared and must be loaded before any entry is probed.
// Depends on sksb_pkg, sksb_ram and sksb_search.
module sorted_key_binary_search
   import sksb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [IDX_W-1:0] req_entry_index,
   input  logic [KEY_W-1:0] req_entry_key,
   input  logic [VAL_W-1:0] req_entry_value,
   input  logic [KEY_W-1:0] req_search_key,
   input  logic [VAL_W-1:0] req_fallback_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_found,
   output logic [VAL_W-1:0] rsp_result_value,
   output logic [IDX_W-1:0] rsp_match_index
);

   mem_req_type        mem_req;
   logic [ENTRY_W-1:0] mem_rd_data;

   sksb_search u_search (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_entry_index    (req_entry_index),
      .req_entry_key      (req_entry_key),
      .req_entry_value    (req_entry_value),
      .req_search_key     (req_search_key),
      .req_fallback_value (req_fallback_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_result_value   (rsp_result_value),
      .rsp_match_index    (rsp_match_index),
      .mem_req            (mem_req),
      .mem_rd_data        (mem_rd_data)
   );

   sksb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- hdl/sksb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module sksb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/sksb_search.sv -----
// Search sequencer: entry count register, binary search control, result register.
// Depends on sksb_pkg; drives the table RAM through mem_req_type.
module sksb_search
   import sksb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic [KEY_W-1:0]   req_entry_key,
   input  logic [VAL_W-1:0]   req_entry_value,
   input  logic [KEY_W-1:0]   req_search_key,
   input  logic [VAL_W-1:0]   req_fallback_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output logic [VAL_W-1:0]   rsp_result_value,
   output logic [IDX_W-1:0]   rsp_match_index,
   output mem_req_type        mem_req,
   input  logic [ENTRY_W-1:0] mem_rd_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CSR_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [BND_W-1:0] low_ff, low_in;
   logic [BND_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] fb_ff, fb_in;
   logic             found_ff, found_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0] index_ff, index_in;

   logic             req_acc;
   logic             slot_free;
   logic [BND_W-1:0] count_sat;
   logic [BND_W-1:0] span;
   logic [IDX_W-1:0] mid_calc;
   logic [KEY_W-1:0] probe_key;
   logic [VAL_W-1:0] probe_val;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign count_sat = (BND_W'(count_ff) >= BND_W'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
                                                               : BND_W'(count_ff);
   // hi_ff is an exclusive bound, so the inclusive span is hi - low - 1
   assign span      = hi_ff - low_ff - BND_W'(1);
   assign mid_calc  = IDX_W'(low_ff + (span >> 1));
   assign probe_key = mem_rd_data[ENTRY_W-1 -: KEY_W];
   assign probe_val = mem_rd_data[VAL_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      low_in       = low_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      fb_in        = fb_ff;
      found_in     = found_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      mem_req      = '0;

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end
      // drop the delivered beat
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_op == OP_LOAD) begin
                  mem_req.wr_en   = (BND_W'(req_entry_index) < BND_W'(TABLE_DEPTH));
                  mem_req.wr_addr = req_entry_index;
                  mem_req.wr_data = {req_entry_key, req_entry_value};
               end else begin
                  key_in   = req_search_key;
                  fb_in    = req_fallback_value;
                  low_in   = '0;
                  hi_in    = count_sat;
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (low_ff < hi_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid_calc;
               mid_in          = mid_calc;
               state_in        = ST_CMP;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               value_in     = fb_ff;
               index_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (key_ff == probe_key) begin
               // hold the read data until the result register frees up
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  found_in     = 1'b1;
                  value_in     = probe_val;
                  index_in     = mid_ff;
                  state_in     = ST_IDLE;
               end
            end else begin
               if (key_ff > probe_key) begin
                  low_in = BND_W'(mid_ff) + BND_W'(1);
               end else begin
                  hi_in = BND_W'(mid_ff);
               end
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      key_ff   <= key_in;
      fb_ff    <= fb_in;
      found_ff <= found_in;
      value_ff <= value_in;
      index_ff <= index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_result_value = value_ff;
   assign rsp_match_index  = index_ff;

endmodule

// ----- hdl/sksb_checker.sv -----
// Port-level checker for sorted_key_binary_search, bound to the top level.
// Depends on sksb_pkg and sorted_key_binary_search_defines.svh.
`include "sorted_key_binary_search_defines.svh"

module sksb_checker
   import sksb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_op,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_found,
   input logic [VAL_W-1:0] rsp_result_value,
   input logic [IDX_W-1:0] rsp_match_index
);

   `SKSB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_found) && $stable(rsp_result_value) && $stable(rsp_match_index),
      "stalled response beat changed")

   `SKSB_ASSERT_NOW(a_miss_index, rsp_valid && !rsp_found, rsp_match_index == '0,
      "miss reported a nonzero index")

   `SKSB_ASSERT_NEXT(a_load_one_cycle, req_valid && !req_stall && req_op == OP_LOAD,
      !req_stall, "load beat stalled the next request")

   `SKSB_ASSERT_NEXT(a_lookup_busy, req_valid && !req_stall && req_op == OP_LOOKUP,
      req_stall, "lookup beat did not hold off the next request")

endmodule

bind sorted_key_binary_search sksb_checker u_sksb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_result_value (rsp_result_value),
   .rsp_match_index  (rsp_match_index)
);

// ----- dv/sorted_key_binary_search_tb.sv -----
// Self-checking testbench for sorted_key_binary_search: loads key/value tables,
// runs lookups under random idling and back-pressure, and checks every response beat.
// Depends on sksb_pkg and the sorted_key_binary_search RTL.
module sorted_key_binary_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sksb_pkg::*;

   localparam int CSR_MAX = (1 << CSR_W) - 1;

   typedef struct packed {
      logic             op;
      logic [IDX_W-1:0] index;
      logic [KEY_W-1:0] ekey;
      logic [VAL_W-1:0] evalue;
      logic [KEY_W-1:0] skey;
      logic [VAL_W-1:0] fallback;
   } search_req_type;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] index;
   } search_rsp_type;

   logic             clock              = 1'b0;
   logic             reset              = 1'b1;
   logic             csr_wr_en          = 1'b0;
   logic [CSR_W-1:0] csr_wr_data        = '0;
   logic             req_valid          = 1'b0;
   logic             req_stall;
   logic             req_op             = OP_LOAD;
   logic [IDX_W-1:0] req_entry_index    = '0;
   logic [KEY_W-1:0] req_entry_key      = '0;
   logic [VAL_W-1:0] req_entry_value    = '0;
   logic [KEY_W-1:0] req_search_key     = '0;
   logic [VAL_W-1:0] req_fallback_value = '0;
   logic             rsp_valid;
   logic             rsp_stall          = 1'b0;
   logic             rsp_found;
   logic [VAL_W-1:0] rsp_result_value;
   logic [IDX_W-1:0] rsp_match_index;

   // shadow of the block's table and entry count
   logic [KEY_W-1:0] key_copy   [TABLE_DEPTH];
   logic [VAL_W-1:0] value_copy [TABLE_DEPTH];
   logic [CSR_W-1:0] count_copy = '0;

   search_rsp_type lookup_q [$];
   search_rsp_type want;
   int          err_count       = 0;
   int          send_idle_pct   = 0;
   int          rsp_stall_pct   = 0;
   int          stall_hold_left = 0;

   sorted_key_binary_search u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_entry_index    (req_entry_index),
      .req_entry_key      (req_entry_key),
      .req_entry_value    (req_entry_value),
      .req_search_key     (req_search_key),
      .req_fallback_value (req_fallback_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_result_value   (rsp_result_value),
      .rsp_match_index    (rsp_match_index)
   );

   always #2 clock = ~clock;

   function automatic int searched_entries();
      return (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy);
   endfunction

   // Update the shadow table for a load, or run the search and queue its answer.
   function automatic void apply_beat(search_req_type b);
      int             lo;
      int             hi;
      int             mid;
      search_rsp_type r;
      if (b.op == OP_LOAD) begin
         key_copy[b.index]   = b.ekey;
         value_copy[b.index] = b.evalue;
         return;
      end
      r.found = 1'b0;
      r.value = b.fallback;
      r.index = '0;
      lo = 0;
      hi = searched_entries() - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (b.skey == key_copy[mid]) begin
            r.found = 1'b1;
            r.value = value_copy[mid];
            r.index = IDX_W'(mid);
            break;
         end
         if (b.skey > key_copy[mid]) lo = mid + 1;
         else hi = mid - 1;
      end
      lookup_q.push_back(r);
   endfunction

   task automatic send_beat(input search_req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= b.op;
      req_entry_index    <= b.index;
      req_entry_key      <= b.ekey;
      req_entry_value    <= b.evalue;
      req_search_key     <= b.skey;
      req_fallback_value <= b.fallback;
      do @(posedge clock); while (req_stall);
      apply_beat(b);
   endtask

   task automatic load_entry(input int idx, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
      search_req_type b;
      b.op       = OP_LOAD;
      b.index    = IDX_W'(idx);
      b.ekey     = k;
      b.evalue   = v;
      b.skey     = KEY_W'($urandom);
      b.fallback = VAL_W'($urandom);
      send_beat(b);
   endtask

   task automatic lookup_key(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] fb);
      search_req_type b;
      b.op       = OP_LOOKUP;
      b.index    = IDX_W'($urandom);
      b.ekey     = KEY_W'($urandom);
      b.evalue   = VAL_W'($urandom);
      b.skey     = k;
      b.fallback = fb;
      send_beat(b);
   endtask

   task automatic write_count(input int v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CSR_W'(v);
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      count_copy = CSR_W'(v);
      @(posedge clock);
   endtask

   // Drop valid, drain all responses, then let a full lookup time pass.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_sorted(input int n);
      int k;
      k = $urandom_range(64);
      for (int i = 0; i < n; i++) begin
         load_entry(i, KEY_W'(k), VAL_W'($urandom));
         k += $urandom_range(900, 1);
      end
   endtask

   task automatic test_empty_table();
      write_count(0);
      lookup_key('0, '0);
      lookup_key('1, '1);
      lookup_key(KEY_W'($urandom), VAL_W'($urandom));
      wait_idle();
   endtask

   task automatic test_full_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         int r;
         r = (i == 0) ? 0 : (i == TABLE_DEPTH - 1) ? 15 : int'($urandom_range(15));
         load_entry(i, KEY_W'(i * 16 + r), VAL_W'($urandom));
      end
      wait_idle();
      write_count(TABLE_DEPTH);
      lookup_key(key_copy[0], '0);
      lookup_key(key_copy[TABLE_DEPTH - 1], '1);
      lookup_key(key_copy[TABLE_DEPTH / 2 - 1], VAL_W'($urandom));
      lookup_key(key_copy[1234] + 16'd1, VAL_W'($urandom));
      lookup_key(key_copy[77], VAL_W'($urandom));
      wait_idle();
      // counts past the depth search the whole table
      write_count(CSR_MAX);
      lookup_key(key_copy[3001], VAL_W'($urandom));
      wait_idle();
      write_count(TABLE_DEPTH + 1);
      lookup_key(key_copy[TABLE_DEPTH - 1], VAL_W'($urandom));
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_count(TABLE_DEPTH);
      stall_hold_left = 400;
      repeat (12) lookup_key(key_copy[$urandom_range(TABLE_DEPTH - 1)], VAL_W'($urandom));
      wait_idle();
      repeat (6) lookup_key(KEY_W'($urandom), VAL_W'($urandom));
      wait_idle();
   endtask

   task automatic test_small_table();
      load_entry(0, 16'd100, 16'hA5A5);
      load_entry(1, 16'd200, 16'h5A5A);
      load_entry(2, 16'd300, 16'hFFFF);
      wait_idle();
      write_count(1);
      lookup_key(16'd100, 16'h1234);
      lookup_key(16'd99, 16'h4321);
      wait_idle();
      write_count(3);
      lookup_key(16'd300, 16'h0000);
      lookup_key(16'd301, 16'hBEEF);
      lookup_key(16'd150, 16'hCAFE);
      wait_idle();
   endtask

   // Unsorted and repeated keys: answer follows the probe order, not the contents.
   task automatic test_unsorted_keys();
      load_entry(0, 16'd500, VAL_W'($urandom));
      load_entry(1, 16'd100, VAL_W'($urandom));
      load_entry(2, 16'd500, VAL_W'($urandom));
      load_entry(3, 16'd900, VAL_W'($urandom));
      load_entry(4, 16'd50, VAL_W'($urandom));
      load_entry(5, 16'd900, VAL_W'($urandom));
      wait_idle();
      write_count(6);
      lookup_key(16'd500, VAL_W'($urandom));
      lookup_key(16'd100, VAL_W'($urandom));
      lookup_key(16'd900, VAL_W'($urandom));
      lookup_key(16'd50, VAL_W'($urandom));
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int sender_pct [4] = '{0, 51, 0, 31};
      int stall_pct  [4] = '{0, 0, 51, 31};
      int sent;
      int n;
      int eff;
      int pick;
      int idx;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = sender_pct[ph];
         rsp_stall_pct = stall_pct[ph];
         sent = 0;
         while (sent < 200) begin
            wait_idle();
            pick = $urandom_range(99);
            if (pick < 10) begin
               n = 0;
            end else if (pick < 20) begin
               n = $urandom_range(CSR_MAX, 65);
            end else begin
               n = $urandom_range(64, 1);
               load_sorted(n);
               sent += n;
               wait_idle();
            end
            write_count(n);
            eff = searched_entries();
            repeat (30) begin
               idx = (eff > 0) ? int'($urandom_range(eff - 1)) : 0;
               if ($urandom_range(99) < 20) begin
                  // mostly refresh a value in place; now and then break the key order
                  if (eff > 0 && $urandom_range(99) < 60)
                     load_entry(idx, key_copy[idx], VAL_W'($urandom));
                  else
                     load_entry($urandom_range(TABLE_DEPTH - 1), KEY_W'($urandom),
                                VAL_W'($urandom));
               end else if (eff > 0 && $urandom_range(99) < 65) begin
                  lookup_key(key_copy[idx], VAL_W'($urandom));
               end else begin
                  lookup_key(KEY_W'($urandom), VAL_W'($urandom));
               end
            end
            sent += 30;
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Receiver: a forced hold wins over the random stall.
   always @(posedge clock) begin
      if (stall_hold_left > 0) begin
         stall_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lookup_q.size() == 0) begin
            $error("response beat with no lookup outstanding");
            err_count++;
         end else begin
            want = lookup_q.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               err_count++;
            end
            if (rsp_result_value !== want.value) begin
               $error("result_value: expected 0x%04h, got 0x%04h", want.value,
                      rsp_result_value);
               err_count++;
            end
            if (rsp_match_index !== want.index) begin
               $error("match_index: expected %0d, got %0d", want.index, rsp_match_index);
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_full_table();
      test_backpressure();
      test_small_table();
      test_unsorted_keys();
      test_random_traffic();
      wait_idle();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
